/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the field splitter.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising clock edge, ignored while reset is asserted.
`define DFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("field splitter assertion failed");
// Check a property on every rising clock edge, reset included.
`define DFS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("field splitter assertion failed");
`else
`define DFS_ASSERT(lbl, clk, rst_n, prop)
`define DFS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/core/dfs_pkg.sv */
// Shared types and constants of the delimited field splitter.
// No dependencies; used by the register block and the top level.
package dfs_pkg;

  // Field count saturates at the smaller of this limit and 255.
  localparam int unsigned MaxFields   = 255;
  localparam int unsigned TallyCapInt = (MaxFields < 255) ? MaxFields : 255;
  localparam logic [7:0]  TallyCap    = 8'(TallyCapInt);

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  typedef enum logic [1:0] {
    KindChar      = 2'd0,
    KindDiscard   = 2'd1,
    KindFieldEnd  = 2'd2,
    KindStringEnd = 2'd3
  } item_kind_e;

  typedef enum logic {
    RegDelimFirst  = 1'b0,
    RegDelimSecond = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] delim_first;
    logic [7:0] delim_second;
  } cfg_t;

endpackage

/* rtl/core/dfs_if.sv */
// Valid/ready stream interfaces for the character input and the result output.
// Stand-alone; no package needed.
interface dfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       string_end;

  modport source (output valid, output char_in, output string_end, input ready);
  modport sink   (input valid, input char_in, input string_end, output ready);
endinterface

interface dfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] char_out;
  logic [7:0] fields_total;
  logic       run_last;

  modport source (output valid, output item_kind, output char_out, output fields_total,
                  output run_last, input ready);
  modport sink   (input valid, input item_kind, input char_out, input fields_total,
                  input run_last, output ready);
endinterface

/* rtl/core/delimited_field_splitter.sv */
// Delimited field splitter: tokenizes a byte stream into fields at two delimiters.
// Depends on dfs_pkg, dfs_if (dfs_in_if, dfs_out_if), dfs_cfg_regs and assert_macros.svh.
//
// One character is taken per transaction on in_i; the block answers with a run of
// result transactions on out_o: visible field characters, a discard marker when an
// opening quote throws away a field's text, field-end markers, and at the last
// character of a string a string-end result carrying the saturating field count.
// run_last flags the final result of each character's run; a character may cause
// no result at all (hidden text, skipped delimiters, an opening quote on an empty
// field). Timing: the tokenizer state is updated in the cycle a character is
// accepted, and its results are captured as a compact run descriptor (discard,
// leading field ends, character, trailing field ends, string end). The result
// serializer turns that descriptor into one result per cycle into the output
// register while out_o accepts them; a character with at most one result flows at
// one per cycle when out_o does not stall. The next character is accepted in
// the cycle the serializer hands out the last result of the current run, or at
// once when no run is pending. The first result passes the descriptor register
// and then the output register. Space mode (either delimiter is a space) holds
// up to MAX_HELD_EMPTY empty-field markers back; a burst releasing them is at
// most MAX_HELD_EMPTY + 3 results long. Delimiters are set over APB at byte
// offsets 0 and 4 and should only change while the block is idle.
`include "assert_macros.svh"

module delimited_field_splitter #(
  parameter int unsigned MAX_HELD_EMPTY = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfs_pkg::PaddrW-1:0]  paddr,
  input  logic [dfs_pkg::PdataW-1:0]  pwdata,
  output logic [dfs_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  // streams
  dfs_in_if.sink                      in_i,
  dfs_out_if.source                   out_o
);

  localparam int unsigned HeldW = $clog2(MAX_HELD_EMPTY + 1);
  // Field-end counts in one run stay below MAX_HELD_EMPTY + 4.
  localparam int unsigned CntW  = HeldW + 1;
  localparam int unsigned SumW  = CntW + 9;
  localparam logic [HeldW-1:0] HeldMax = HeldW'(MAX_HELD_EMPTY);

  dfs_pkg::cfg_t cfg;

  dfs_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Tokenizer state
  // ---------------------------------------------------------------------------
  logic             start_q;      // next character opens a string
  logic             prior_sp_q;   // previous character was a space
  logic             inq_q;        // inside double quotes
  logic             hide_q;       // text after a closing quote is hidden
  logic             nonempty_q;   // field has shown a visible character
  logic [HeldW-1:0] held_q;       // empty-field markers held back
  logic [7:0]       tally_q;      // field-end markers sent in this string

  // Close a field: returns {markers to send now, new held count}.
  function automatic logic [CntW+HeldW-1:0] end_field(input logic             sm,
                                                      input logic             ne,
                                                      input logic [HeldW-1:0] h);
    logic [CntW-1:0]  fe;
    logic [HeldW-1:0] hn;
    if (sm && !ne) begin
      if (h >= HeldMax) begin
        fe = CntW'(1);
        hn = h;
      end else begin
        fe = '0;
        hn = h + HeldW'(1);
      end
    end else begin
      fe = CntW'(h) + CntW'(1);
      hn = '0;
    end
    return {fe, hn};
  endfunction

  logic [7:0]          in_char;
  logic                in_last;
  logic                in_fire;
  logic                space_mode;
  logic                is_delim;
  logic                skip;
  logic [CntW+HeldW-1:0] ef;
  logic [HeldW-1:0]    h_n;
  logic                ne_n;
  logic                inq_n;
  logic                hide_n;
  logic [CntW-1:0]     pre_n;
  logic [CntW-1:0]     post_n;
  logic                disc_n;
  logic                chv_n;
  logic [SumW-1:0]     tally_sum;
  logic [7:0]          tally_n;
  logic                run_any;

  assign in_char    = in_i.char_in;
  assign in_last    = in_i.string_end;
  assign space_mode = (cfg.delim_first == dfs_pkg::CharSpace) ||
                      (cfg.delim_second == dfs_pkg::CharSpace);
  assign is_delim   = ((in_char == cfg.delim_first) || (in_char == cfg.delim_second)) &&
                      !inq_q;

  // Work out the run of results and the state one character leaves.
  always_comb begin
    h_n    = held_q;
    ne_n   = nonempty_q;
    inq_n  = inq_q;
    hide_n = hide_q;
    pre_n  = '0;
    post_n = '0;
    disc_n = 1'b0;
    chv_n  = 1'b0;
    skip   = 1'b0;
    ef     = '0;
    if (is_delim) begin
      skip = space_mode && (start_q || prior_sp_q);
      if (!skip) begin
        ef     = end_field(space_mode, ne_n, h_n);
        post_n = ef[CntW+HeldW-1:HeldW];
        h_n    = ef[HeldW-1:0];
        ne_n   = 1'b0;
        hide_n = 1'b0;
        inq_n  = 1'b0;
        // trailing delimiter adds an empty field
        if (in_last && !start_q) begin
          ef     = end_field(space_mode, 1'b0, h_n);
          post_n = post_n + ef[CntW+HeldW-1:HeldW];
          h_n    = ef[HeldW-1:0];
        end
      end
    end else if (in_char == dfs_pkg::CharQuote) begin
      if (inq_n) begin
        inq_n  = 1'b0;
        hide_n = 1'b1;
      end else begin
        disc_n = ne_n;
        ne_n   = 1'b0;
        hide_n = 1'b0;
        inq_n  = 1'b1;
      end
      if (in_last) begin
        ef     = end_field(space_mode, ne_n, h_n);
        post_n = ef[CntW+HeldW-1:HeldW];
        h_n    = ef[HeldW-1:0];
        ne_n   = 1'b0;
        hide_n = 1'b0;
        inq_n  = 1'b0;
      end
    end else begin
      if (!hide_n) begin
        // held markers go out ahead of the visible character
        pre_n = CntW'(h_n);
        h_n   = '0;
        chv_n = 1'b1;
        ne_n  = 1'b1;
      end
      if (in_last) begin
        ef     = end_field(space_mode, ne_n, h_n);
        post_n = ef[CntW+HeldW-1:HeldW];
        h_n    = ef[HeldW-1:0];
        ne_n   = 1'b0;
        hide_n = 1'b0;
        inq_n  = 1'b0;
      end
    end
    // at string end, send all held markers but the last one
    if (in_last && (h_n != '0)) begin
      post_n = post_n + CntW'(h_n - HeldW'(1));
    end
  end

  assign tally_sum = SumW'(tally_q) + SumW'(pre_n) + SumW'(post_n);
  assign tally_n   = (tally_sum > SumW'(dfs_pkg::TallyCap)) ? dfs_pkg::TallyCap
                                                            : tally_sum[7:0];
  assign run_any   = disc_n || (pre_n != '0) || chv_n || (post_n != '0) || in_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= 1'b1;
      prior_sp_q <= 1'b0;
      inq_q      <= 1'b0;
      hide_q     <= 1'b0;
      nonempty_q <= 1'b0;
      held_q     <= '0;
      tally_q    <= '0;
    end else if (in_fire) begin
      if (in_last) begin
        // string done: back to the reset state
        start_q    <= 1'b1;
        prior_sp_q <= 1'b0;
        inq_q      <= 1'b0;
        hide_q     <= 1'b0;
        nonempty_q <= 1'b0;
        held_q     <= '0;
        tally_q    <= '0;
      end else begin
        start_q    <= 1'b0;
        prior_sp_q <= (in_char == dfs_pkg::CharSpace);
        inq_q      <= inq_n;
        hide_q     <= hide_n;
        nonempty_q <= ne_n;
        held_q     <= h_n;
        tally_q    <= tally_n;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run descriptor and result serializer
  // ---------------------------------------------------------------------------
  logic             d_disc_q;
  logic [CntW-1:0]  d_pre_q;
  logic             d_chv_q;
  logic [7:0]       d_ch_q;
  logic [CntW-1:0]  d_post_q;
  logic             d_end_q;
  logic [7:0]       d_total_q;

  logic             nd_disc;
  logic [CntW-1:0]  nd_pre;
  logic             nd_chv;
  logic [CntW-1:0]  nd_post;
  logic             nd_end;
  dfs_pkg::item_kind_e pick_kind;
  logic             pick_last;
  logic             run_busy;
  logic             adv;

  logic                out_valid_q;
  dfs_pkg::item_kind_e out_kind_q;
  logic [7:0]          out_ch_q;
  logic [7:0]          out_total_q;
  logic                out_last_q;

  assign run_busy = d_disc_q || (d_pre_q != '0) || d_chv_q || (d_post_q != '0) || d_end_q;
  assign adv      = run_busy && (!out_valid_q || out_o.ready);

  // Take the first pending result in run order and retire it.
  always_comb begin
    nd_disc = d_disc_q;
    nd_pre  = d_pre_q;
    nd_chv  = d_chv_q;
    nd_post = d_post_q;
    nd_end  = d_end_q;
    if (d_disc_q) begin
      pick_kind = dfs_pkg::KindDiscard;
      nd_disc   = 1'b0;
    end else if (d_pre_q != '0) begin
      pick_kind = dfs_pkg::KindFieldEnd;
      nd_pre    = d_pre_q - CntW'(1);
    end else if (d_chv_q) begin
      pick_kind = dfs_pkg::KindChar;
      nd_chv    = 1'b0;
    end else if (d_post_q != '0) begin
      pick_kind = dfs_pkg::KindFieldEnd;
      nd_post   = d_post_q - CntW'(1);
    end else begin
      pick_kind = dfs_pkg::KindStringEnd;
      nd_end    = 1'b0;
    end
    pick_last = !(nd_disc || (nd_pre != '0) || nd_chv || (nd_post != '0) || nd_end);
  end

  // Accept while no run is pending, or as the pending run hands out its last result.
  assign in_i.ready = !run_busy || (adv && pick_last);
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_disc_q <= 1'b0;
      d_pre_q  <= '0;
      d_chv_q  <= 1'b0;
      d_post_q <= '0;
      d_end_q  <= 1'b0;
    end else if (in_fire && run_any) begin
      d_disc_q <= disc_n;
      d_pre_q  <= pre_n;
      d_chv_q  <= chv_n;
      d_post_q <= post_n;
      d_end_q  <= in_last;
    end else if (adv) begin
      d_disc_q <= nd_disc;
      d_pre_q  <= nd_pre;
      d_chv_q  <= nd_chv;
      d_post_q <= nd_post;
      d_end_q  <= nd_end;
    end
  end

  // Run payload: loaded with the descriptor.
  always_ff @(posedge clk_i) begin
    if (in_fire && run_any) begin
      d_ch_q    <= in_char;
      d_total_q <= tally_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_kind_q  <= pick_kind;
      out_ch_q    <= (pick_kind == dfs_pkg::KindChar) ? d_ch_q : 8'd0;
      out_total_q <= (pick_kind == dfs_pkg::KindStringEnd) ? d_total_q : 8'd0;
      out_last_q  <= pick_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.item_kind    = out_kind_q;
  assign out_o.char_out     = out_ch_q;
  assign out_o.fields_total = out_total_q;
  assign out_o.run_last     = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DFS_ASSERT_ALWAYS(OutIdleInReset_A, clk_i, !rst_ni |-> !out_valid_q)
  `DFS_ASSERT(HeldBound_A, clk_i, rst_ni, held_q <= HeldMax)
  `DFS_ASSERT(TallyBound_A, clk_i, rst_ni, tally_q <= dfs_pkg::TallyCap)
  `DFS_ASSERT(AcceptOnRunEnd_A, clk_i, rst_ni, in_fire && run_busy |-> adv && pick_last)
  `DFS_ASSERT(StringEndLast_A, clk_i, rst_ni, out_valid_q && (out_kind_q == dfs_pkg::KindStringEnd) |-> out_last_q)
  `DFS_ASSERT(StringEndClears_A, clk_i, rst_ni, in_fire && in_last |=> start_q && (held_q == '0) && (tally_q == '0))

endmodule

/* rtl/core/dfs_cfg_regs.sv */
// APB register block holding the two delimiter codes.
// Depends on dfs_pkg for the address width, register indexes and cfg_t.
module dfs_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfs_pkg::PaddrW-1:0]  paddr,
  input  logic [dfs_pkg::PdataW-1:0]  pwdata,
  output logic [dfs_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  output dfs_pkg::cfg_t               cfg_o
);

  dfs_pkg::cfg_t     cfg_q;
  dfs_pkg::reg_idx_e idx;
  logic              wr_en;

  // Registers sit on 32-bit words; byte offset bits are ignored.
  assign idx    = dfs_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim_first  <= dfs_pkg::CharComma;
      cfg_q.delim_second <= dfs_pkg::CharComma;
    end else if (wr_en) begin
      case (idx)
        dfs_pkg::RegDelimFirst:  cfg_q.delim_first  <= pwdata[7:0];
        dfs_pkg::RegDelimSecond: cfg_q.delim_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dfs_pkg::RegDelimFirst:  prdata = {(dfs_pkg::PdataW-8)'(0), cfg_q.delim_first};
      dfs_pkg::RegDelimSecond: prdata = {(dfs_pkg::PdataW-8)'(0), cfg_q.delim_second};
      default:                 prdata = '0;
    endcase
  end

endmodule
